### design/svn_pkg.sv
`timescale 1ns / 1ps

package svn_pkg;

	// Item kinds as they arrive on the input side
	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_TRI   = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		STS_OK     = 3'd0,
		STS_DEGEN  = 3'd1,
		STS_SKIP   = 3'd2,
		STS_FULL   = 3'd3,
		STS_BADIDX = 3'd4,
		STS_NOGEO  = 3'd5
	} status_t;

	// Work for the back end, decided by the front end
	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_LOAD   = 2'd1,
		OP_TRI    = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	localparam int IDX_W     = 16;
	localparam int POS_MAX_W = 32;
	localparam int VIDX_W    = 10;
	localparam int NORM_W    = 16;
	localparam int ACC_W     = 64;

	localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd32767;

	typedef struct packed {
		op_t                   op;
		status_t               status;
		logic [VIDX_W-1:0]     vidx;
		logic [IDX_W-1:0]      ca;
		logic [IDX_W-1:0]      cb;
		logic [IDX_W-1:0]      cc;
		logic [POS_MAX_W-1:0]  px;
		logic [POS_MAX_W-1:0]  py;
		logic [POS_MAX_W-1:0]  pz;
	} cmd_t;

	typedef struct packed {
		status_t               status;
		logic [VIDX_W-1:0]     vidx;
		logic [NORM_W-1:0]     nx;
		logic [NORM_W-1:0]     ny;
		logic [NORM_W-1:0]     nz;
	} res_t;

	// Saturating 64-bit signed add
	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s[ACC_W-1:0];
	endfunction

endpackage

### design/svn_ram.sv
`timescale 1ns / 1ps

module svn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/svn_fifo.sv
`timescale 1ns / 1ps

module svn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Hold the stored items
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

### design/svn_front.sv
`timescale 1ns / 1ps

module svn_front #(
	parameter int VERTEX_DEPTH  = 1024,
	parameter int POSITION_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      kind,
	input  logic signed [POSITION_BITS-1:0] pos_x,
	input  logic signed [POSITION_BITS-1:0] pos_y,
	input  logic signed [POSITION_BITS-1:0] pos_z,
	input  logic [15:0]                     corner_a,
	input  logic [15:0]                     corner_b,
	input  logic [15:0]                     corner_c,
	input  logic                            cmd_full,
	output logic                            cmd_push,
	output svn_pkg::cmd_t                   cmd
);

	localparam int CW   = $clog2(VERTEX_DEPTH + 1);
	localparam int CMPW = svn_pkg::IDX_W + 1;

	logic [CW-1:0]   count_q;
	logic            seen_q;
	logic            accept;
	logic [CMPW-1:0] cnt_ext;
	logic            store_full;
	logic            tri_bad;
	logic            read_bad;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign cmd_push = accept;

	assign cnt_ext    = CMPW'(count_q);
	assign store_full = (count_q == CW'(VERTEX_DEPTH));
	assign tri_bad    = (CMPW'(corner_a) >= cnt_ext) || (CMPW'(corner_b) >= cnt_ext)
		|| (CMPW'(corner_c) >= cnt_ext);
	assign read_bad   = (CMPW'(corner_a) >= cnt_ext);

	// Classify the item and settle trivial results here
	always_comb begin
		cmd        = '0;
		cmd.op     = svn_pkg::OP_REPORT;
		cmd.status = svn_pkg::STS_OK;
		cmd.ca     = corner_a;
		cmd.cb     = corner_b;
		cmd.cc     = corner_c;
		cmd.px     = svn_pkg::POS_MAX_W'(pos_x);
		cmd.py     = svn_pkg::POS_MAX_W'(pos_y);
		cmd.pz     = svn_pkg::POS_MAX_W'(pos_z);
		unique case (svn_pkg::kind_t'(kind))
			svn_pkg::KIND_CLEAR: begin
				cmd.op = svn_pkg::OP_REPORT;
			end
			svn_pkg::KIND_LOAD: begin
				if (store_full) begin
					cmd.status = svn_pkg::STS_FULL;
				end else begin
					cmd.op   = svn_pkg::OP_LOAD;
					cmd.ca   = svn_pkg::IDX_W'(count_q);
					cmd.vidx = svn_pkg::VIDX_W'(count_q);
				end
			end
			svn_pkg::KIND_TRI: begin
				if (tri_bad) begin
					cmd.status = svn_pkg::STS_SKIP;
				end else begin
					cmd.op = svn_pkg::OP_TRI;
				end
			end
			svn_pkg::KIND_READ: begin
				cmd.vidx = corner_a[svn_pkg::VIDX_W-1:0];
				if (count_q == '0 || !seen_q) begin
					cmd.status = svn_pkg::STS_NOGEO;
				end else if (read_bad) begin
					cmd.status = svn_pkg::STS_BADIDX;
				end else begin
					cmd.op = svn_pkg::OP_READ;
				end
			end
			default: begin
				cmd.op = svn_pkg::OP_REPORT;
			end
		endcase
	end

	// Track vertex count and whether a triangle came since the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			unique case (svn_pkg::kind_t'(kind))
				svn_pkg::KIND_CLEAR: begin
					count_q <= '0;
					seen_q  <= 1'b0;
				end
				svn_pkg::KIND_LOAD: begin
					if (!store_full) begin
						count_q <= count_q + CW'(1);
					end
				end
				svn_pkg::KIND_TRI: begin
					seen_q <= 1'b1;
				end
				default: begin
					seen_q <= seen_q;
				end
			endcase
		end
	end

endmodule

### design/svn_back.sv
`timescale 1ns / 1ps

module svn_back #(
	parameter int VERTEX_DEPTH  = 1024,
	parameter int POSITION_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  svn_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output svn_pkg::res_t res
);

	localparam int IW = $clog2(VERTEX_DEPTH);
	localparam int P  = POSITION_BITS;
	localparam int EW = P + 1;
	localparam int PW = 2 * EW;
	localparam int XW = (PW + 1 > 64) ? PW + 1 : 64;
	localparam int AW = svn_pkg::ACC_W;

	typedef enum logic [16:0] {
		S_IDLE = 17'b00000000000000001,
		S_LOAD = 17'b00000000000000010,
		S_PRD  = 17'b00000000000000100,
		S_PLT  = 17'b00000000000001000,
		S_EDGE = 17'b00000000000010000,
		S_MUL  = 17'b00000000000100000,
		S_CRS  = 17'b00000000001000000,
		S_ARD  = 17'b00000000010000000,
		S_AWR  = 17'b00000000100000000,
		S_RRD  = 17'b00000001000000000,
		S_RCHK = 17'b00000010000000000,
		S_SHF  = 17'b00000100000000000,
		S_SQ   = 17'b00001000000000000,
		S_BIT  = 17'b00010000000000000,
		S_BM   = 17'b00100000000000000,
		S_BC   = 17'b01000000000000000,
		S_OUT  = 17'b10000000000000000
	} state_t;

	function automatic logic signed [AW-1:0] sat_x(input logic signed [XW-1:0] v);
		if (v[XW-1:AW-1] == {(XW-AW+1){v[XW-1]}}) begin
			return v[AW-1:0];
		end
		return v[XW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
	endfunction

	state_t               state_q;
	logic [1:0]           ck_q;
	logic [2:0]           mi_q;
	logic [1:0]           si_q;
	logic [1:0]           ci_q;
	logic [3:0]           bi_q;

	svn_pkg::cmd_t        cmd_q;
	svn_pkg::res_t        res_q;
	logic signed [EW-1:0] pv_q [3][3];
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [PW-1:0] prod_q [6];
	logic signed [AW-1:0] cr_q [3];
	logic [AW-1:0]        mag_q [3];
	logic                 neg_q [3];
	logic [29:0]          sq_q [3];
	logic [31:0]          ssum_q;
	logic [14:0]          r_q;
	logic [31:0]          tsq_q;
	logic [63:0]          lhs_q;

	logic [IW-1:0]        corner_sel;
	logic                 pos_we;
	logic [3*P-1:0]       pos_wdata;
	logic [3*P-1:0]       pos_rdata;
	logic                 acc_we;
	logic [IW-1:0]        acc_waddr;
	logic [IW-1:0]        acc_raddr;
	logic [3*AW-1:0]      acc_wdata;
	logic [3*AW-1:0]      acc_rdata;
	logic signed [AW-1:0] ax;
	logic signed [AW-1:0] ay;
	logic signed [AW-1:0] az;
	logic signed [EW-1:0] mul_a;
	logic signed [EW-1:0] mul_b;
	logic signed [PW-1:0] prod_w;
	logic [29:0]          sq_w;
	logic [14:0]          trial;
	logic [15:0]          tval;
	logic [31:0]          tsq_w;
	logic [63:0]          lhs_w;
	logic                 fits;
	logic [14:0]          r_new;
	logic [15:0]          nval;
	logic                 big;

	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign res_push = (state_q == S_OUT) && !res_full;
	assign res      = res_q;

	// Pick the corner index for the current step
	always_comb begin
		unique case (ck_q)
			2'd0:    corner_sel = cmd_q.ca[IW-1:0];
			2'd1:    corner_sel = cmd_q.cb[IW-1:0];
			2'd2:    corner_sel = cmd_q.cc[IW-1:0];
			default: corner_sel = cmd_q.ca[IW-1:0];
		endcase
	end

	assign ax = acc_rdata[AW-1:0];
	assign ay = acc_rdata[2*AW-1:AW];
	assign az = acc_rdata[3*AW-1:2*AW];

	// Memory ports
	assign pos_we    = (state_q == S_LOAD);
	assign pos_wdata = {cmd_q.pz[P-1:0], cmd_q.py[P-1:0], cmd_q.px[P-1:0]};
	assign acc_we    = (state_q == S_LOAD) || (state_q == S_AWR);
	assign acc_waddr = (state_q == S_LOAD) ? cmd_q.ca[IW-1:0] : corner_sel;
	assign acc_raddr = (state_q == S_RRD) ? cmd_q.ca[IW-1:0] : corner_sel;
	assign acc_wdata = (state_q == S_LOAD) ? '0 :
		{svn_pkg::sat_add(az, cr_q[2]), svn_pkg::sat_add(ay, cr_q[1]),
		 svn_pkg::sat_add(ax, cr_q[0])};

	svn_ram #(.WIDTH(3 * P), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (cmd_q.ca[IW-1:0]),
		.wdata (pos_wdata),
		.raddr (corner_sel),
		.rdata (pos_rdata)
	);

	svn_ram #(.WIDTH(3 * AW), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// Select operands for one cross-product term per cycle
	always_comb begin
		unique case (mi_q)
			3'd0: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			3'd5: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
			default: begin mul_a = e1_q[0]; mul_b = e2_q[0]; end
		endcase
	end

	assign prod_w = PW'(mul_a) * PW'(mul_b);

	// Normalization arithmetic: squares, trial bit and its test
	assign sq_w  = 30'(mag_q[si_q][14:0]) * 30'(mag_q[si_q][14:0]);
	assign big   = (|mag_q[0][AW-1:15]) || (|mag_q[1][AW-1:15]) || (|mag_q[2][AW-1:15]);
	assign trial = r_q | (15'd1 << bi_q);
	assign tval  = {trial, 1'b0} - 16'd1;
	assign tsq_w = 32'(tval) * 32'(tval);
	assign lhs_w = 64'(tsq_q) * 64'(ssum_q);
	assign fits  = (lhs_q <= {2'b00, sq_q[ci_q], 32'd0});
	assign r_new = fits ? trial : r_q;
	assign nval  = neg_q[ci_q] ? (16'd0 - {1'b0, r_new}) : {1'b0, r_new};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ck_q    <= '0;
			mi_q    <= '0;
			si_q    <= '0;
			ci_q    <= '0;
			bi_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						ck_q <= '0;
						unique case (cmd.op)
							svn_pkg::OP_REPORT: state_q <= S_OUT;
							svn_pkg::OP_LOAD:   state_q <= S_LOAD;
							svn_pkg::OP_TRI:    state_q <= S_PRD;
							svn_pkg::OP_READ:   state_q <= S_RRD;
							default:            state_q <= S_OUT;
						endcase
					end
				end
				S_LOAD: state_q <= S_OUT;
				S_PRD:  state_q <= S_PLT;
				S_PLT: begin
					if (ck_q == 2'd2) begin
						state_q <= S_EDGE;
					end else begin
						ck_q    <= ck_q + 2'd1;
						state_q <= S_PRD;
					end
				end
				S_EDGE: begin
					mi_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mi_q == 3'd5) begin
						state_q <= S_CRS;
					end else begin
						mi_q <= mi_q + 3'd1;
					end
				end
				S_CRS: begin
					ck_q    <= '0;
					state_q <= S_ARD;
				end
				S_ARD: state_q <= S_AWR;
				S_AWR: begin
					if (ck_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						ck_q    <= ck_q + 2'd1;
						state_q <= S_ARD;
					end
				end
				S_RRD: state_q <= S_RCHK;
				S_RCHK: begin
					if (ax == '0 && ay == '0 && az == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SHF;
					end
				end
				S_SHF: begin
					if (!big) begin
						si_q    <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (si_q == 2'd2) begin
						ci_q    <= '0;
						bi_q    <= 4'd14;
						state_q <= S_BIT;
					end else begin
						si_q <= si_q + 2'd1;
					end
				end
				S_BIT: state_q <= S_BM;
				S_BM:  state_q <= S_BC;
				S_BC: begin
					if (bi_q == '0) begin
						bi_q <= 4'd14;
						if (ci_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							ci_q    <= ci_q + 2'd1;
							state_q <= S_BIT;
						end
					end else begin
						bi_q    <= bi_q - 4'd1;
						state_q <= S_BIT;
					end
				end
				S_OUT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					cmd_q        <= cmd;
					res_q.status <= cmd.status;
					res_q.vidx   <= cmd.vidx;
					res_q.nx     <= '0;
					res_q.ny     <= '0;
					res_q.nz     <= '0;
				end
			end
			S_PLT: begin
				pv_q[ck_q][0] <= EW'($signed(pos_rdata[P-1:0]));
				pv_q[ck_q][1] <= EW'($signed(pos_rdata[2*P-1:P]));
				pv_q[ck_q][2] <= EW'($signed(pos_rdata[3*P-1:2*P]));
			end
			S_EDGE: begin
				for (int j = 0; j < 3; j++) begin
					e1_q[j] <= pv_q[1][j] - pv_q[0][j];
					e2_q[j] <= pv_q[2][j] - pv_q[0][j];
				end
			end
			S_MUL: begin
				prod_q[mi_q] <= prod_w;
			end
			S_CRS: begin
				for (int k = 0; k < 3; k++) begin
					cr_q[k] <= sat_x(XW'(prod_q[2*k]) - XW'(prod_q[2*k+1]));
				end
			end
			S_RCHK: begin
				if (ax == '0 && ay == '0 && az == '0) begin
					res_q.status <= svn_pkg::STS_DEGEN;
					res_q.ny     <= svn_pkg::NORM_ONE;
				end
				mag_q[0] <= ax[AW-1] ? (64'd0 - ax) : ax;
				mag_q[1] <= ay[AW-1] ? (64'd0 - ay) : ay;
				mag_q[2] <= az[AW-1] ? (64'd0 - az) : az;
				neg_q[0] <= ax[AW-1];
				neg_q[1] <= ay[AW-1];
				neg_q[2] <= az[AW-1];
				ssum_q   <= '0;
			end
			S_SHF: begin
				if (big) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end
			end
			S_SQ: begin
				sq_q[si_q] <= sq_w;
				ssum_q     <= ssum_q + 32'(sq_w);
				r_q        <= '0;
			end
			S_BIT: tsq_q <= tsq_w;
			S_BM:  lhs_q <= lhs_w;
			S_BC: begin
				if (bi_q == '0) begin
					r_q <= '0;
					unique case (ci_q)
						2'd0:    res_q.nx <= nval;
						2'd1:    res_q.ny <= nval;
						2'd2:    res_q.nz <= nval;
						default: res_q.nz <= nval;
					endcase
				end else begin
					r_q <= r_new;
				end
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	a_out_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> state_q == S_IDLE)
		else $error("result push not followed by idle");

	a_sq_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQ |-> !big)
		else $error("squaring a magnitude that is still too wide");

	a_awr_after_ard: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AWR |-> $past(state_q) == S_ARD)
		else $error("accumulator write without a preceding read");

	a_bc_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BC |-> $past(state_q, 2) == S_BIT)
		else $error("trial compare out of step with its multiplies");

endmodule

### design/smooth_vertex_normals_core.sv
`timescale 1ns / 1ps

// Area-weighted smooth vertex normals. Push clear, vertex, triangle and read
// items; each gives exactly one result, in order. The front end classifies
// items (range checks, store full, no geometry) and queues them; the back end
// runs them one at a time on a vertex position RAM and a 192-bit accumulator
// RAM. Back-end work per item: clear and error reports go straight to the
// result stage; a vertex load stores its position; a triangle does three
// position reads, six sequential 25x25 products at the default position
// width and three accumulator read-modify-writes; a zero-sum read reports a
// degenerate result; a normalizing read right-shifts by s (0..49) to bring
// the largest accumulator magnitude below 2^15, then resolves 45 trial bits through one 16x16 and one
// 32x32 multiplier. No clearing pass: a load zeroes its own accumulator slot.
module smooth_vertex_normals_core #(
	parameter int VERTEX_DEPTH  = 1024,
	parameter int POSITION_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      kind,
	input  logic signed [POSITION_BITS-1:0] pos_x,
	input  logic signed [POSITION_BITS-1:0] pos_y,
	input  logic signed [POSITION_BITS-1:0] pos_z,
	input  logic [15:0]                     corner_a,
	input  logic [15:0]                     corner_b,
	input  logic [15:0]                     corner_c,
	output logic                            empty,
	input  logic                            pop,
	output logic [2:0]                      status,
	output logic [9:0]                      vertex_index,
	output logic signed [15:0]              norm_x,
	output logic signed [15:0]              norm_y,
	output logic signed [15:0]              norm_z
);

	svn_pkg::cmd_t cmd_in;
	svn_pkg::cmd_t cmd_head;
	svn_pkg::res_t res_in;
	svn_pkg::res_t res_head;
	logic          cmd_push;
	logic          cmd_full;
	logic          cmd_empty;
	logic          cmd_pop;
	logic          res_push;
	logic          res_full;

	// Accept and classify items
	svn_front #(.VERTEX_DEPTH(VERTEX_DEPTH), .POSITION_BITS(POSITION_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.corner_a (corner_a),
		.corner_b (corner_b),
		.corner_c (corner_c),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Decouple front from back
	svn_fifo #(.WIDTH($bits(svn_pkg::cmd_t)), .DEPTH(2)) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	// Carry out stores, accumulation and normalization
	svn_back #(.VERTEX_DEPTH(VERTEX_DEPTH), .POSITION_BITS(POSITION_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Hold finished results for the consumer
	svn_fifo #(.WIDTH($bits(svn_pkg::res_t)), .DEPTH(2)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign status       = res_head.status;
	assign vertex_index = res_head.vidx;
	assign norm_x       = res_head.nx;
	assign norm_y       = res_head.ny;
	assign norm_z       = res_head.nz;

endmodule
